@@ hdl/assert_macros.svh @@
// shared assertion macros for the design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

// implication after a fixed number of cycles
`define ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error("delayed implication failed");

`endif

@@ hdl/ndvi_pkg.sv @@
package ndvi_pkg;

    // quotient bits per color channel, one per divider cell
    localparam int QUOT_BITS = 8;

    // accept edge to result edge: front stage, cells, output stage
    localparam int PIPE_LAT = QUOT_BITS + 2;

    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 32;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_OPACITY = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_NODATA  = 8'd1;

    localparam logic [7:0]  ALPHA_RESET  = 8'hFF;
    localparam logic [31:0] NODATA_RESET = 32'h0000_0000;

    typedef struct packed {
        logic valid;
        logic fallback;
    } t_ctrl;

endpackage

@@ hdl/ndvi_pixel_colorizer_unit.sv @@
// ndvi pixel colorizer: one signed nir/red sample pair in, one argb pixel out
//
// input channel: an item is taken at a rising edge with i_start high and
//   o_busy low; o_busy drops the cycle after reset release and stays low
// result channel: o_done strobes for one cycle with o_pixel_argb and
//   o_used_fallback; the receiver cannot stall, results are never held
// throughput: 1 item per cycle, set by the 8-cell divider chain in which
//   each cell resolves one quotient bit of green and red per clock
// datapath: front stage checks flags, sum and sign, and forms 255*part and
//   the aligned |sum|; 8 cells do restoring division; output stage packs
//   {alpha, red, green, 0} or selects the no-data color
// configuration: i_cfg_valid/o_cfg_ready with i_cfg_index, i_cfg_data;
//   index 0 opacity alpha (low 8 bits), index 1 no-data color; other
//   indexes are dropped; write only while no item is in flight
// reset: synchronous active low; clears the pipe valids, loads alpha 255 and
//   no-data color 0, holds o_busy high and o_cfg_ready low until the cycle
//   after release
`include "assert_macros.svh"

module ndvi_pixel_colorizer_unit #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // item channel
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic signed [SAMPLE_BITS-1:0]        i_nir_sample,
    input  logic signed [SAMPLE_BITS-1:0]        i_red_sample,
    input  logic                                 i_nir_missing,
    input  logic                                 i_red_missing,
    // result channel
    output logic                                 o_done,
    output logic [31:0]                          o_pixel_argb,
    output logic                                 o_used_fallback,
    // configuration channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ndvi_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [ndvi_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam int QB = ndvi_pkg::QUOT_BITS;
    localparam int RW = SAMPLE_BITS + 1 + QB;

    logic            r_ready;
    logic            in_accept;
    logic [7:0]      r_alpha;
    logic [31:0]     r_nodata;

    // divider chain taps, index 0 is the front stage output
    ndvi_pkg::t_ctrl chain_ctrl  [0:QB];
    logic [RW-1:0]   chain_div   [0:QB];
    logic [RW-1:0]   chain_rem_g [0:QB];
    logic [RW-1:0]   chain_rem_r [0:QB];
    logic [QB-1:0]   chain_q_g   [0:QB];
    logic [QB-1:0]   chain_q_r   [0:QB];

    logic            r_done;
    logic [31:0]     n_pixel_argb;
    logic [31:0]     r_pixel_argb;
    logic            r_used_fallback;
    logic            out_pack_ok;

    // ready comes up the cycle after reset is released
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
        end
    end

    assign o_busy      = ~r_ready;
    assign o_cfg_ready = r_ready;
    assign in_accept   = i_start & r_ready;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= ndvi_pkg::ALPHA_RESET;
            r_nodata <= ndvi_pkg::NODATA_RESET;
        end else if (i_cfg_valid && r_ready) begin
            case (i_cfg_index)
                ndvi_pkg::REG_OPACITY: r_alpha  <= i_cfg_data[7:0];
                ndvi_pkg::REG_NODATA:  r_nodata <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    ndvi_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (in_accept),
        .i_nir         (i_nir_sample),
        .i_red         (i_red_sample),
        .i_nir_missing (i_nir_missing),
        .i_red_missing (i_red_missing),
        .o_ctrl        (chain_ctrl[0]),
        .o_div         (chain_div[0]),
        .o_rem_g       (chain_rem_g[0]),
        .o_rem_r       (chain_rem_r[0])
    );

    assign chain_q_g[0] = '0;
    assign chain_q_r[0] = '0;

    // one cell per quotient bit, msb first; divisor halves along the chain
    for (genvar k = 0; k < QB; k++) begin : g_cell
        ndvi_cell #(
            .RW (RW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (chain_ctrl[k]),
            .i_div   (chain_div[k]),
            .i_rem_g (chain_rem_g[k]),
            .i_rem_r (chain_rem_r[k]),
            .i_q_g   (chain_q_g[k]),
            .i_q_r   (chain_q_r[k]),
            .o_ctrl  (chain_ctrl[k+1]),
            .o_div   (chain_div[k+1]),
            .o_rem_g (chain_rem_g[k+1]),
            .o_rem_r (chain_rem_r[k+1]),
            .o_q_g   (chain_q_g[k+1]),
            .o_q_r   (chain_q_r[k+1])
        );
    end

    // pack the pixel or substitute the no-data color
    assign n_pixel_argb = chain_ctrl[QB].fallback ? r_nodata
                        : {r_alpha, chain_q_r[QB], chain_q_g[QB], 8'h00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= chain_ctrl[QB].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pixel_argb    <= n_pixel_argb;
        r_used_fallback <= chain_ctrl[QB].fallback;
    end

    assign o_done          = r_done;
    assign o_pixel_argb    = r_pixel_argb;
    assign o_used_fallback = r_used_fallback;

    assign out_pack_ok = (r_pixel_argb[31:24] == r_alpha) && (r_pixel_argb[7:0] == 8'h00);

    // every accepted item comes out after the fixed latency, and only those
    `ASSERT_DELAY(a_item_out, i_clk, i_rst_n, in_accept, ndvi_pkg::PIPE_LAT, r_done)
    `ASSERT_IMPL(a_out_had_item, i_clk, i_rst_n, r_done, $past(in_accept, ndvi_pkg::PIPE_LAT))
    // computed pixels carry the configured alpha and zero blue
    `ASSERT_IMPL(a_pixel_pack, i_clk, i_rst_n, r_done && !r_used_fallback, out_pack_ok)
    `ASSERT_IMPL(a_fallback_color, i_clk, i_rst_n, r_done && r_used_fallback, r_pixel_argb == r_nodata)
    // once out of reset the block keeps taking items
    `ASSERT_NEXT(a_stays_ready, i_clk, i_rst_n, !o_busy, !o_busy)

endmodule

@@ hdl/ndvi_front.sv @@
module ndvi_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [SAMPLE_BITS-1:0] i_nir,
    input  logic signed [SAMPLE_BITS-1:0] i_red,
    input  logic                          i_nir_missing,
    input  logic                          i_red_missing,
    output ndvi_pkg::t_ctrl               o_ctrl,
    output logic [SAMPLE_BITS+ndvi_pkg::QUOT_BITS:0] o_div,
    output logic [SAMPLE_BITS+ndvi_pkg::QUOT_BITS:0] o_rem_g,
    output logic [SAMPLE_BITS+ndvi_pkg::QUOT_BITS:0] o_rem_r
);

    localparam int MW = SAMPLE_BITS + 1;
    localparam int RW = MW + ndvi_pkg::QUOT_BITS;

    logic [MW-1:0] nir_ext;
    logic [MW-1:0] red_ext;
    logic [MW-1:0] sum;
    logic [MW-1:0] nir_mag;
    logic [MW-1:0] red_mag;
    logic [MW-1:0] sum_mag;
    logic          sum_zero;
    logic          nir_bad;
    logic          red_bad;

    ndvi_pkg::t_ctrl n_ctrl;
    ndvi_pkg::t_ctrl r_ctrl;
    logic [RW-1:0]   n_div;
    logic [RW-1:0]   n_rem_g;
    logic [RW-1:0]   n_rem_r;
    logic [RW-1:0]   r_div;
    logic [RW-1:0]   r_rem_g;
    logic [RW-1:0]   r_rem_r;

    assign nir_ext = MW'(i_nir);
    assign red_ext = MW'(i_red);
    assign sum     = nir_ext + red_ext;

    assign nir_mag = nir_ext[MW-1] ? (~nir_ext + 1'b1) : nir_ext;
    assign red_mag = red_ext[MW-1] ? (~red_ext + 1'b1) : red_ext;
    assign sum_mag = sum[MW-1]     ? (~sum + 1'b1)     : sum;

    // a nonzero sample whose sign differs from the sum puts ndvi outside -1..1
    assign sum_zero = (sum == '0);
    assign nir_bad  = (nir_ext != '0) && (nir_ext[MW-1] != sum[MW-1]);
    assign red_bad  = (red_ext != '0) && (red_ext[MW-1] != sum[MW-1]);

    always_comb begin
        n_ctrl.valid    = i_valid;
        n_ctrl.fallback = i_nir_missing | i_red_missing | sum_zero | nir_bad | red_bad;
        // dividend 255 * part, divisor aligned to the top quotient bit
        n_rem_g = {nir_mag, ndvi_pkg::QUOT_BITS'(0)} - RW'(nir_mag);
        n_rem_r = {red_mag, ndvi_pkg::QUOT_BITS'(0)} - RW'(red_mag);
        n_div   = RW'({sum_mag, (ndvi_pkg::QUOT_BITS-1)'(0)});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= n_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div   <= n_div;
        r_rem_g <= n_rem_g;
        r_rem_r <= n_rem_r;
    end

    assign o_ctrl  = r_ctrl;
    assign o_div   = r_div;
    assign o_rem_g = r_rem_g;
    assign o_rem_r = r_rem_r;

endmodule

@@ hdl/ndvi_cell.sv @@
module ndvi_cell #(
    parameter int RW = 25
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ndvi_pkg::t_ctrl                   i_ctrl,
    input  logic [RW-1:0]                     i_div,
    input  logic [RW-1:0]                     i_rem_g,
    input  logic [RW-1:0]                     i_rem_r,
    input  logic [ndvi_pkg::QUOT_BITS-1:0]    i_q_g,
    input  logic [ndvi_pkg::QUOT_BITS-1:0]    i_q_r,
    output ndvi_pkg::t_ctrl                   o_ctrl,
    output logic [RW-1:0]                     o_div,
    output logic [RW-1:0]                     o_rem_g,
    output logic [RW-1:0]                     o_rem_r,
    output logic [ndvi_pkg::QUOT_BITS-1:0]    o_q_g,
    output logic [ndvi_pkg::QUOT_BITS-1:0]    o_q_r
);

    logic fit_g;
    logic fit_r;

    ndvi_pkg::t_ctrl                r_ctrl;
    logic [RW-1:0]                  n_rem_g;
    logic [RW-1:0]                  n_rem_r;
    logic [RW-1:0]                  r_div;
    logic [RW-1:0]                  r_rem_g;
    logic [RW-1:0]                  r_rem_r;
    logic [ndvi_pkg::QUOT_BITS-1:0] n_q_g;
    logic [ndvi_pkg::QUOT_BITS-1:0] n_q_r;
    logic [ndvi_pkg::QUOT_BITS-1:0] r_q_g;
    logic [ndvi_pkg::QUOT_BITS-1:0] r_q_r;

    // one restoring step per lane, both lanes share the divisor
    assign fit_g   = (i_rem_g >= i_div);
    assign fit_r   = (i_rem_r >= i_div);
    assign n_rem_g = fit_g ? (i_rem_g - i_div) : i_rem_g;
    assign n_rem_r = fit_r ? (i_rem_r - i_div) : i_rem_r;
    assign n_q_g   = {i_q_g[ndvi_pkg::QUOT_BITS-2:0], fit_g};
    assign n_q_r   = {i_q_r[ndvi_pkg::QUOT_BITS-2:0], fit_r};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div   <= i_div >> 1;
        r_rem_g <= n_rem_g;
        r_rem_r <= n_rem_r;
        r_q_g   <= n_q_g;
        r_q_r   <= n_q_r;
    end

    assign o_ctrl  = r_ctrl;
    assign o_div   = r_div;
    assign o_rem_g = r_rem_g;
    assign o_rem_r = r_rem_r;
    assign o_q_g   = r_q_g;
    assign o_q_r   = r_q_r;

endmodule
